// ===== rtl/mgsa_pkg.sv =====
// ----------------------------------------------------------------------------
// mgsa_pkg
// shared types and constants of the max gap slot allocator
// ----------------------------------------------------------------------------
package mgsa_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int CFG_W         = 7;
    localparam int SLOT_W        = 6;
    localparam int STAT_W        = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // request codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // response status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_REL = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [SLOT_W-1:0] slot_to_release;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic [STAT_W-1:0] status;
    } t_rsp;

    // control from the sequencer to the gap unit
    typedef struct packed {
        logic clear;
        logic step;
        logic last_step;
    } t_scan_ctl;

endpackage

// ===== rtl/mgsa_gap_unit.sv =====
// ----------------------------------------------------------------------------
// mgsa_gap_unit
// shared subtract and compare unit that tracks the widest gap during a scan
// ----------------------------------------------------------------------------
module mgsa_gap_unit
    import mgsa_pkg::*;
#(
    parameter int IW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_scan_ctl     i_ctl,
    input  logic [IW-1:0] i_idx,
    input  logic          i_occ,
    output logic          o_have_prev,
    output logic [IW-1:0] o_nxt_best_d,
    output logic [IW-1:0] o_nxt_best_s
);

    logic          r_have_prev;
    logic [IW-1:0] r_prev;
    logic [IW-1:0] r_best_d;
    logic [IW-1:0] r_best_s;

    logic [IW-1:0] diff;
    logic [IW-1:0] cand_d;
    logic [IW-1:0] cand_s;
    logic          hit;
    logic          take;

    assign diff = i_idx - r_prev;

    always_comb begin
        if (i_ctl.last_step) begin
            // right edge run offers the last slot
            cand_d = diff;
            cand_s = i_idx;
            hit    = r_have_prev;
        end else if (!r_have_prev) begin
            // left edge run offers slot zero
            cand_d = i_idx;
            cand_s = '0;
            hit    = i_occ;
        end else begin
            cand_d = diff >> 1;
            cand_s = r_prev + (diff >> 1);
            hit    = i_occ;
        end
    end

    assign take         = hit && (cand_d > r_best_d);
    assign o_nxt_best_d = take ? cand_d : r_best_d;
    assign o_nxt_best_s = take ? cand_s : r_best_s;
    assign o_have_prev  = r_have_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev      <= '0;
            r_best_d    <= '0;
            r_best_s    <= '0;
        end else if (i_ctl.clear) begin
            r_have_prev <= 1'b0;
            r_prev      <= '0;
            r_best_d    <= '0;
            r_best_s    <= '0;
        end else if (i_ctl.step) begin
            r_best_d <= o_nxt_best_d;
            r_best_s <= o_nxt_best_s;
            if (!i_ctl.last_step && i_occ) begin
                r_prev      <= i_idx;
                r_have_prev <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/max_gap_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// max_gap_slot_allocator
// occupancy map of a row of slots, allocates the slot farthest from any taken
// ----------------------------------------------------------------------------
// allocate: the scan walks the row, n = row length (one map bit per
//   cycle through the shared gap unit, then a final step for the right edge)
// release: done in the cycle after start, busy stays low
// a new transaction can start in the cycle that done is high
// the receiver cannot stall: each result is flagged by o_done for exactly one cycle
// synchronous active-low reset frees all slots and sets the row length to 64
// ----------------------------------------------------------------------------
module max_gap_slot_allocator
    import mgsa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    // response channel
    output logic             o_done,
    output t_rsp             o_rsp,
    // row length register
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    // common width for row length compares
    localparam int CW = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]           r_state;
    logic [MAX_SLOTS-1:0] r_map;
    logic [CFG_W-1:0]     r_cfg;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        r_last;
    logic                 r_done;
    t_rsp                 r_rsp;

    // effective row length, saturated to 1..MAX_SLOTS
    logic [CW-1:0] cfg_ext;
    logic [CW-1:0] eff_len;
    logic [CW-1:0] last_wide;
    logic [CW-1:0] rel_ext;
    logic          rel_in_range;
    logic [IW-1:0] rel_idx;

    // gap unit
    t_scan_ctl     scan_ctl;
    logic          have_prev;
    logic [IW-1:0] nxt_best_d;
    logic [IW-1:0] nxt_best_s;
    logic [IW+SLOT_W-1:0] grant_wide;

    logic accept;

    assign cfg_ext = {{(CW-CFG_W){1'b0}}, r_cfg};

    always_comb begin
        if (cfg_ext == '0) begin
            eff_len = CW'(1);
        end else if (cfg_ext > CW'(MAX_SLOTS)) begin
            eff_len = CW'(MAX_SLOTS);
        end else begin
            eff_len = cfg_ext;
        end
    end

    assign last_wide    = eff_len - CW'(1);
    assign rel_ext      = {{(CW-SLOT_W){1'b0}}, i_req.slot_to_release};
    assign rel_in_range = rel_ext < eff_len;
    assign rel_idx      = rel_ext[IW-1:0];

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    // slot number widened then cut to the field width
    assign grant_wide = {{SLOT_W{1'b0}}, nxt_best_s};

    always_comb begin
        scan_ctl = '0;
        unique case (r_state)
            S_IDLE: scan_ctl.clear = accept && (i_req.cmd == CMD_ALLOC);
            S_SCAN: scan_ctl.step  = 1'b1;
            S_FIN: begin
                scan_ctl.step      = 1'b1;
                scan_ctl.last_step = 1'b1;
            end
            default: scan_ctl = '0;
        endcase
    end

    mgsa_gap_unit #(
        .IW (IW)
    ) u_gap (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_idx        (r_idx),
        .i_occ        (r_map[r_idx]),
        .o_have_prev  (have_prev),
        .o_nxt_best_d (nxt_best_d),
        .o_nxt_best_s (nxt_best_s)
    );

    // row length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg <= i_cfg_data;
        end
    end

    // sequencer and occupancy map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_map   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_req.cmd == CMD_RELEASE) begin
                            r_done                <= 1'b1;
                            r_rsp.granted_slot    <= '0;
                            if (rel_in_range && r_map[rel_idx]) begin
                                r_map[rel_idx] <= 1'b0;
                                r_rsp.status   <= STAT_OK;
                            end else begin
                                r_rsp.status   <= STAT_BAD_REL;
                            end
                        end else begin
                            // start the scan at slot zero
                            r_idx   <= '0;
                            r_last  <= last_wide[IW-1:0];
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx == r_last) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                    if (!have_prev) begin
                        // empty row takes slot zero
                        r_map[0]           <= 1'b1;
                        r_rsp.granted_slot <= '0;
                        r_rsp.status       <= STAT_OK;
                    end else if (nxt_best_d == '0) begin
                        r_rsp.granted_slot <= '0;
                        r_rsp.status       <= STAT_FULL;
                    end else begin
                        r_map[nxt_best_s]  <= 1'b1;
                        r_rsp.granted_slot <= grant_wide[SLOT_W-1:0];
                        r_rsp.status       <= STAT_OK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== tb/sv/tb_max_gap_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_max_gap_slot_allocator
// self-checking bench for the max gap slot allocator: a directed table covers
// empty, full and narrow rows, bad releases and row length saturation, then
// random phases with changing row lengths run mostly well-formed allocate and
// release traffic, every response checked against a local occupancy model
// ----------------------------------------------------------------------------
module tb_max_gap_slot_allocator;
    import mgsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_MAX        = MAX_SLOTS_DEF;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;   // outlasts the longest allocate
    localparam int N_DIR_ROWS     = 29;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // one line of the directed table; typed rows carry their own answer
    typedef struct {
        t_row_kind         kind;
        logic              cmd;
        logic [CFG_W-1:0]  arg;       // slot for requests, row length for writes
        bit                typed;
        logic [SLOT_W-1:0] exp_slot;
        logic [STAT_W-1:0] exp_stat;
    } t_dir_row;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_req             i_req       = '0;
    logic             o_done;
    t_rsp             o_rsp;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    // local copy of the occupancy map and the row length register
    bit [ROW_MAX-1:0] seat_map    = '0;
    bit [CFG_W-1:0]   row_len_cfg = CFG_RESET;

    // responses still owed by the block, oldest first
    t_rsp rsp_expected_q[$];

    int fail_count   = 0;
    int stall_cycles = 0;
    int items_sent   = 0;
    int burst_left   = 0;

    // empty row, right edge, middle, bad releases, narrow rows, saturation
    t_dir_row directed_rows [N_DIR_ROWS] = '{
        '{ROW_REQ, CMD_ALLOC,   7'd0,   1'b1, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_ALLOC,   7'd42,  1'b1, 6'd63, STAT_OK},
        '{ROW_REQ, CMD_ALLOC,   7'd0,   1'b1, 6'd31, STAT_OK},
        '{ROW_REQ, CMD_RELEASE, 7'd63,  1'b1, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_RELEASE, 7'd63,  1'b1, 6'd0,  STAT_BAD_REL},
        '{ROW_REQ, CMD_ALLOC,   7'd63,  1'b0, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_RELEASE, 7'd0,   1'b1, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_ALLOC,   7'd21,  1'b0, 6'd0,  STAT_OK},
        '{ROW_CFG, CMD_ALLOC,   7'd1,   1'b0, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_ALLOC,   7'd0,   1'b1, 6'd0,  STAT_FULL},
        '{ROW_REQ, CMD_RELEASE, 7'd31,  1'b1, 6'd0,  STAT_BAD_REL},
        '{ROW_REQ, CMD_RELEASE, 7'd0,   1'b1, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_ALLOC,   7'd0,   1'b1, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_ALLOC,   7'd0,   1'b1, 6'd0,  STAT_FULL},
        '{ROW_CFG, CMD_ALLOC,   7'd0,   1'b0, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_RELEASE, 7'd0,   1'b1, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_ALLOC,   7'd0,   1'b1, 6'd0,  STAT_OK},
        '{ROW_CFG, CMD_ALLOC,   7'd2,   1'b0, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_ALLOC,   7'd0,   1'b1, 6'd1,  STAT_OK},
        '{ROW_REQ, CMD_ALLOC,   7'd0,   1'b1, 6'd0,  STAT_FULL},
        '{ROW_REQ, CMD_RELEASE, 7'd1,   1'b1, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_RELEASE, 7'd1,   1'b1, 6'd0,  STAT_BAD_REL},
        '{ROW_CFG, CMD_ALLOC,   7'd127, 1'b0, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_ALLOC,   7'd0,   1'b0, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_RELEASE, 7'd63,  1'b1, 6'd0,  STAT_OK},
        '{ROW_CFG, CMD_ALLOC,   7'd64,  1'b0, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_ALLOC,   7'd0,   1'b0, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_RELEASE, 7'd40,  1'b0, 6'd0,  STAT_OK},
        '{ROW_REQ, CMD_ALLOC,   7'd0,   1'b0, 6'd0,  STAT_OK}
    };

    max_gap_slot_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // row length as the block sees it: register saturated to 1..ROW_MAX
    function automatic int active_row_len();
        if (row_len_cfg == 0)
            return 1;
        if (row_len_cfg > ROW_MAX)
            return ROW_MAX;
        return int'(row_len_cfg);
    endfunction

    // applies one request to the local map and returns the response it earns
    function automatic t_rsp serve_request(t_req r);
        t_rsp rsp;
        int   n;
        int   prev;
        bit   have_prev;
        int   best_d;
        int   best_s;
        int   d;
        rsp       = '{granted_slot: '0, status: STAT_OK};
        n         = active_row_len();
        prev      = 0;
        have_prev = 1'b0;
        best_d    = 0;
        best_s    = 0;
        if (r.cmd == CMD_RELEASE) begin
            // out of range or already free: flagged, map untouched
            if (int'(r.slot_to_release) < n && seat_map[r.slot_to_release])
                seat_map[r.slot_to_release] = 1'b0;
            else
                rsp.status = STAT_BAD_REL;
            return rsp;
        end
        // walk held slots: left edge counts in full, inner gaps count half
        for (int i = 0; i < n; i++) begin
            if (seat_map[i]) begin
                if (!have_prev) begin
                    if (i > best_d) begin
                        best_d = i;
                        best_s = 0;
                    end
                end else begin
                    d = (i - prev) / 2;
                    if (d > best_d) begin
                        best_d = d;
                        best_s = prev + d;
                    end
                end
                prev      = i;
                have_prev = 1'b1;
            end
        end
        // empty row hands out slot 0, otherwise try the right edge
        if (!have_prev) begin
            best_d = 1;
            best_s = 0;
        end else if (prev < n - 1 && n - 1 - prev > best_d) begin
            best_d = n - 1 - prev;
            best_s = n - 1;
        end
        if (best_d == 0) begin
            rsp.status = STAT_FULL;
        end else begin
            seat_map[best_s]  = 1'b1;
            rsp.granted_slot  = SLOT_W'(best_s);
        end
        return rsp;
    endfunction

    // all tasks below are entered just after a rising edge

    // hold start low until every owed response has come back
    task automatic wait_all_returned();
        start <= 1'b0;
        @(posedge i_clk);
        while (rsp_expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    // row length write, only with the block idle
    task automatic write_row_length(input logic [CFG_W-1:0] len);
        wait_all_returned();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        row_len_cfg = len;
        i_cfg_valid <= 1'b0;
    endtask

    // one request transaction; the sender works in bursts with random gaps
    task automatic issue_request(input t_req r, input bit typed, input t_rsp typed_rsp);
        t_rsp predicted;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        start <= 1'b1;
        i_req <= r;
        do
            @(posedge i_clk);
        while (busy);
        predicted = serve_request(r);
        rsp_expected_q.push_back(typed ? typed_rsp : predicted);
        items_sent++;
    endtask

    // response checker and watchdog; responses cannot be held off
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (i_rst_n && o_done) begin
            if (rsp_expected_q.size() == 0) begin
                $error("response with none owed: granted_slot %0d status %0d",
                       o_rsp.granted_slot, o_rsp.status);
                fail_count++;
            end else begin
                want = rsp_expected_q.pop_front();
                if (o_rsp.granted_slot !== want.granted_slot) begin
                    $error("granted_slot: expected %0d, actual %0d",
                           want.granted_slot, o_rsp.granted_slot);
                    fail_count++;
                end
                if (o_rsp.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_rsp.status);
                    fail_count++;
                end
            end
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_req     r;
        t_rsp     typed_rsp;
        int       held_now[$];
        int       pick;
        int       phase_len;
        int       n;
        logic [CFG_W-1:0] len;

        // reset once, then the map is all free and the row is 64 long
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                write_row_length(directed_rows[k].arg);
            end else begin
                r.cmd                  = directed_rows[k].cmd;
                r.slot_to_release      = directed_rows[k].arg[SLOT_W-1:0];
                typed_rsp.granted_slot = directed_rows[k].exp_slot;
                typed_rsp.status       = directed_rows[k].exp_stat;
                issue_request(r, directed_rows[k].typed, typed_rsp);
            end
        end

        // random phases, each under its own row length
        typed_rsp = '0;
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       len = 7'd64;
                1:       len = CFG_W'($urandom_range(65, 127));
                2:       len = 7'd0;
                3, 4, 5, 6: len = CFG_W'($urandom_range(1, 12));
                7, 8:    len = CFG_W'($urandom_range(13, 63));
                default: len = CFG_W'($urandom_range(0, 127));
            endcase
            write_row_length(len);
            n = active_row_len();
            phase_len = (n <= 12) ? $urandom_range(30, 80) : $urandom_range(60, 140);
            repeat (phase_len) begin
                // occasional pause until the block has answered everything
                if ($urandom_range(0, 199) == 0)
                    wait_all_returned();
                held_now.delete();
                for (int s = 0; s < n; s++)
                    if (seat_map[s])
                        held_now.push_back(s);
                pick = $urandom_range(0, 99);
                r.slot_to_release = SLOT_W'($urandom_range(0, ROW_MAX - 1));
                if (pick < 50 || (pick < 85 && held_now.size() == 0)) begin
                    r.cmd = CMD_ALLOC;
                end else if (pick < 85) begin
                    // release of a slot that is really held
                    r.cmd             = CMD_RELEASE;
                    r.slot_to_release = SLOT_W'(held_now[$urandom_range(0, held_now.size() - 1)]);
                end else begin
                    // noise: any slot, often free or beyond the row
                    r.cmd = CMD_RELEASE;
                end
                issue_request(r, 1'b0, typed_rsp);
            end
        end

        // wait out the last responses and make sure nothing else shows up
        wait_all_returned();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && rsp_expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mgsa_pkg.sv
rtl/mgsa_gap_unit.sv
rtl/max_gap_slot_allocator.sv
tb/sv/tb_max_gap_slot_allocator.sv
